[rtl/esc_rsr_pkg.sv]
// Shared types, constants and helpers of the motor speed regulator.
`default_nettype none

package esc_rsr_pkg;

  // Serial divider sizes: the widest dividend is |raw| * 600 or duty * 32767.
  localparam int unsigned DVD_W   = 26;
  localparam int unsigned DVS_W   = 16;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned MUL_A_W = 17;
  localparam int unsigned MUL_K_W = 16;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_K_W;

  localparam logic [CNT_W-1:0]   DIV_LAST      = CNT_W'(DVD_W - 1);

  localparam logic [DVS_W-1:0]   POLES         = 16'd14;
  localparam logic [2:0]         ADJUST_PERIOD = 3'd5;
  localparam logic [7:0]         IDENT_ALIVE   = 8'hAB;
  localparam logic [9:0]         DUTY_MAX      = 10'd1000;
  localparam logic [MUL_K_W-1:0] RPM_SCALE     = 16'd600;
  localparam logic [MUL_K_W-1:0] MAP_SCALE     = 16'd100;
  localparam logic [MUL_K_W-1:0] THR_SCALE     = 16'd32767;
  localparam logic [DVS_W-1:0]   THR_DIV       = 16'd1000;
  localparam logic [17:0]        ERR_COARSE    = 18'd2000;
  localparam logic [17:0]        ERR_FINE      = 18'd100;
  localparam logic [6:0]         STEP_COARSE   = 7'd100;
  localparam logic [6:0]         STEP_MID      = 7'd10;
  localparam logic [6:0]         STEP_FINE     = 7'd1;

  typedef enum logic [2:0] {
    FUNC_TICK      = 3'd0,
    FUNC_SET_RPM   = 3'd1,
    FUNC_SET_DUTY  = 3'd2,
    FUNC_POWER_ON  = 3'd3,
    FUNC_POWER_OFF = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    REG_SLOPE     = 3'd0,
    REG_INTERCEPT = 3'd1,
    REG_MIN_RPM   = 3'd2,
    REG_MAX_RPM   = 3'd3,
    REG_MIN_DUTY  = 3'd4,
    REG_MAX_DUTY  = 3'd5,
    REG_DEAD_BAND = 3'd6,
    REG_REVERSE   = 3'd7
  } reg_idx_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DIV  = 6'b000100,
    S_POST = 6'b001000,
    S_ADJ  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    JOB_SPEED = 2'd0,
    JOB_MAP   = 2'd1,
    JOB_THR   = 2'd2
  } job_e;

  typedef struct packed {
    logic [2:0]        func;
    logic signed [15:0] raw_count;
    logic [7:0]        ident_byte;
    logic [15:0]       value;
    logic              write_ok;
  } esc_in_t;

  typedef struct packed {
    logic              send;
    logic signed [15:0] throttle;
    logic signed [15:0] measured_rpm;
    logic [9:0]        duty_now;
    logic              status;
  } esc_out_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [9:0] sat_duty(input logic [DVD_W-1:0] d);
    return (d > DVD_W'(DUTY_MAX)) ? DUTY_MAX : d[9:0];
  endfunction

endpackage

`default_nettype wire

[rtl/esc_rsr_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module esc_rsr_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  esc_rsr_pkg::div_req_t req_i,
  output esc_rsr_pkg::div_rsp_t rsp_o
);
  import esc_rsr_pkg::*;

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // The dividend register shifts out its top bit and takes the quotient bit in.
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DVD_W-2:0], fits};
      rem_d = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      if (cnt_q == DIV_LAST) begin
        cnt_d  = '0;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && cnt_q == '0)
    else $error("divider done while still iterating");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (dvs_q == '0 || rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q == DIV_LAST && !req_i.start |=> done_q)
    else $error("divider missed its done pulse");

endmodule

`default_nettype wire

[rtl/esc_rpm_step_regulator_unit.sv]
// Power on, power off and unused selectors go straight to the output state. Set duty and a tick
// without a step take one divider pass (a tick with no target and a still motor also passes the
// adjust state); set rpm and a tick that keeps, lowers or re-sends the duty take two, an upward
// step three. Each pass loads the operands, forms the 26 quotient bits, raises done and has its
// result used. One word is in work at a time: the next is taken once the previous is output.
// Reset: asynchronous, active low; loads the register defaults and clears all but the data words.
`default_nettype none

module esc_rpm_step_regulator_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  esc_rsr_pkg::esc_in_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output esc_rsr_pkg::esc_out_t out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import esc_rsr_pkg::*;

  // Configuration registers
  logic [15:0] slope_q, intercept_q, min_rpm_q, max_rpm_q, dead_band_q;
  logic [9:0]  min_duty_q, max_duty_q;
  logic        reverse_q;
  logic        cfg_wr;

  // Control and regulator state
  state_e      state_q, state_d;
  job_e        job_q, job_d;
  esc_in_t     in_q, in_d;
  logic [15:0] speed_q, speed_d;
  logic [2:0]  tick_cnt_q, tick_cnt_d;
  logic        pend_q, pend_d;
  logic        powered_q, powered_d;
  logic [15:0] target_q, target_d;
  logic [9:0]  duty_q, duty_d;
  logic [6:0]  step_q, step_d;
  logic        res_send_q, res_send_d;
  logic        res_status_q, res_status_d;
  logic [15:0] res_thr_q, res_thr_d;
  esc_out_t    out_q, out_d;
  logic        out_valid_q, out_valid_d;

  // Datapath
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_K_W-1:0] mul_k;
  logic [DVS_W-1:0]   div_dvs;
  logic [PROD_W-1:0]  prod;
  logic [MUL_A_W-1:0] raw_abs;
  logic [15:0]        map_r;
  logic               map_ge;
  logic [15:0]        map_off;
  logic [9:0]         map_res;
  logic [15:0]        speed_new;
  logic [15:0]        thr_word;
  logic               in_accept;
  logic               out_load;
  logic               live;
  logic               pend_new;
  logic signed [17:0] act18, tgt18, db18, diff18, adiff18;
  logic               rising, falling, act_pos;
  logic [6:0]         step_new;
  logic [10:0]        fall_p, fall_lim;
  logic [10:0]        rise_p, rise_cap, rise_lim;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;

  // ---------------------------------------------------------------- config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q     <= 16'd100;
      intercept_q <= '0;
      min_rpm_q   <= '0;
      max_rpm_q   <= 16'hFFFF;
      min_duty_q  <= '0;
      max_duty_q  <= DUTY_MAX;
      dead_band_q <= '0;
      reverse_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_SLOPE:     slope_q     <= pwdata[15:0];
        REG_INTERCEPT: intercept_q <= pwdata[15:0];
        REG_MIN_RPM:   min_rpm_q   <= pwdata[15:0];
        REG_MAX_RPM:   max_rpm_q   <= pwdata[15:0];
        REG_MIN_DUTY:  min_duty_q  <= pwdata[9:0];
        REG_MAX_DUTY:  max_duty_q  <= pwdata[9:0];
        REG_DEAD_BAND: dead_band_q <= pwdata[15:0];
        REG_REVERSE:   reverse_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_SLOPE:     prdata = {16'd0, slope_q};
      REG_INTERCEPT: prdata = {16'd0, intercept_q};
      REG_MIN_RPM:   prdata = {16'd0, min_rpm_q};
      REG_MAX_RPM:   prdata = {16'd0, max_rpm_q};
      REG_MIN_DUTY:  prdata = {22'd0, min_duty_q};
      REG_MAX_DUTY:  prdata = {22'd0, max_duty_q};
      REG_DEAD_BAND: prdata = {16'd0, dead_band_q};
      REG_REVERSE:   prdata = {31'd0, reverse_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- operands
  assign raw_abs = in_q.raw_count[15] ? (17'd0 - {in_q.raw_count[15], in_q.raw_count})
                                      : {1'b0, in_q.raw_count};
  assign map_r   = (in_q.func == FUNC_SET_RPM) ? in_q.value : max_rpm_q;
  assign map_ge  = map_r >= intercept_q;
  assign map_off = map_r - intercept_q;

  always_comb begin
    case (job_q)
      JOB_SPEED: begin
        mul_a   = raw_abs;
        mul_k   = RPM_SCALE;
        div_dvs = POLES;
      end
      JOB_MAP: begin
        mul_a   = map_ge ? {1'b0, map_off} : '0;
        mul_k   = MAP_SCALE;
        div_dvs = slope_q;
      end
      JOB_THR: begin
        mul_a   = {7'd0, duty_q};
        mul_k   = THR_SCALE;
        div_dvs = THR_DIV;
      end
      default: begin
        mul_a   = '0;
        mul_k   = '0;
        div_dvs = THR_DIV;
      end
    endcase
  end

  // The product goes straight into the divider's shift register.
  assign prod             = mul_a * mul_k;
  assign div_req.start    = (state_q == S_MUL);
  assign div_req.dividend = prod[DVD_W-1:0];
  assign div_req.divisor  = div_dvs;

  esc_rsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- results of a pass
  assign speed_new = in_q.raw_count[15] ? (16'd0 - div_rsp.quotient[15:0])
                                        : div_rsp.quotient[15:0];
  // A zero slope divides to all ones, which saturates to full duty.
  assign map_res   = (!map_ge || map_r < min_rpm_q) ? 10'd0 : sat_duty(div_rsp.quotient);
  assign thr_word  = reverse_q ? (16'd0 - div_rsp.quotient[15:0]) : div_rsp.quotient[15:0];

  assign live     = (in_q.ident_byte == IDENT_ALIVE);
  assign pend_new = pend_q || (tick_cnt_q >= ADJUST_PERIOD);

  // Error against the target, taken from the speed already stored.
  assign act18   = {{2{speed_q[15]}}, speed_q};
  assign tgt18   = {2'b00, target_q};
  assign db18    = {2'b00, dead_band_q};
  assign rising  = (act18 + db18) < tgt18;
  assign falling = act18 > (tgt18 + db18);
  assign diff18  = tgt18 - act18;
  assign adiff18 = diff18[17] ? -diff18 : diff18;
  assign act_pos = !speed_q[15] && (speed_q != 16'd0);

  always_comb begin
    if (adiff18 > ERR_COARSE) begin
      step_new = STEP_COARSE;
    end else if (adiff18 > ERR_FINE) begin
      step_new = STEP_MID;
    end else begin
      step_new = STEP_FINE;
    end
  end

  assign fall_p   = ({1'b0, duty_q} < {4'd0, step_new}) ? 11'd0
                                                         : ({1'b0, duty_q} - {4'd0, step_new});
  assign fall_lim = (fall_p < {1'b0, min_duty_q}) ? {1'b0, min_duty_q} : fall_p;

  assign rise_p   = {1'b0, duty_q} + {4'd0, step_q};
  assign rise_cap = (rise_p > {1'b0, map_res}) ? {1'b0, map_res} : rise_p;
  assign rise_lim = (rise_cap > {1'b0, max_duty_q}) ? {1'b0, max_duty_q} : rise_cap;

  // ---------------------------------------------------------------- sequencer
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    in_d         = in_q;
    speed_d      = speed_q;
    tick_cnt_d   = tick_cnt_q;
    pend_d       = pend_q;
    powered_d    = powered_q;
    target_d     = target_q;
    duty_d       = duty_q;
    step_d       = step_q;
    res_send_d   = res_send_q;
    res_status_d = res_status_q;
    res_thr_d    = res_thr_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          in_d         = in_data_i;
          res_send_d   = 1'b0;
          res_status_d = 1'b0;
          res_thr_d    = '0;
          case (in_data_i.func)
            FUNC_TICK: begin
              job_d   = JOB_SPEED;
              state_d = S_MUL;
            end
            FUNC_SET_RPM: begin
              job_d   = JOB_MAP;
              state_d = S_MUL;
            end
            FUNC_SET_DUTY: begin
              target_d     = '0;
              duty_d       = sat_duty(DVD_W'(in_data_i.value));
              res_send_d   = 1'b1;
              res_status_d = 1'b1;
              job_d        = JOB_THR;
              state_d      = S_MUL;
            end
            FUNC_POWER_ON: begin
              powered_d    = 1'b1;
              res_send_d   = 1'b1;
              res_status_d = in_data_i.write_ok;
              state_d      = S_OUT;
            end
            FUNC_POWER_OFF: begin
              powered_d    = 1'b0;
              target_d     = '0;
              res_send_d   = 1'b1;
              res_status_d = in_data_i.write_ok;
              state_d      = S_OUT;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end

      S_MUL: begin
        state_d = S_DIV;
      end

      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_POST;
        end
      end

      S_POST: begin
        case (job_q)
          JOB_SPEED: begin
            speed_d = speed_new;
            if (!live) begin
              state_d = S_OUT;
            end else begin
              tick_cnt_d   = (tick_cnt_q >= ADJUST_PERIOD) ? 3'd0 : tick_cnt_q + 3'd1;
              res_status_d = 1'b1;
              if (pend_new && powered_q) begin
                pend_d  = 1'b0;
                state_d = S_ADJ;
              end else begin
                pend_d  = pend_new;
                state_d = S_OUT;
              end
            end
          end
          JOB_MAP: begin
            if (in_q.func == FUNC_SET_RPM) begin
              duty_d       = map_res;
              res_send_d   = 1'b1;
              res_status_d = in_q.write_ok;
              if (in_q.write_ok) begin
                target_d = in_q.value;
              end
            end else begin
              // Upward step of a tick, capped by the mapped duty of max_rpm.
              duty_d = sat_duty(DVD_W'(rise_lim));
            end
            job_d   = JOB_THR;
            state_d = S_MUL;
          end
          JOB_THR: begin
            res_thr_d = thr_word;
            state_d   = S_OUT;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end

      S_ADJ: begin
        if (target_q == '0) begin
          // No target: report the current duty only while the measured speed is above zero.
          res_status_d = 1'b0;
          res_send_d   = act_pos;
          job_d        = JOB_THR;
          state_d      = act_pos ? S_MUL : S_OUT;
        end else begin
          res_status_d = 1'b1;
          res_send_d   = 1'b1;
          step_d       = step_new;
          if (rising) begin
            job_d = JOB_MAP;
          end else begin
            if (falling) begin
              duty_d = sat_duty(DVD_W'(fall_lim));
            end
            job_d = JOB_THR;
          end
          state_d = S_MUL;
        end
      end

      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- output word
  always_comb begin
    out_d              = out_q;
    out_d.send         = res_send_q;
    out_d.throttle     = res_thr_q;
    out_d.measured_rpm = speed_q;
    out_d.duty_now     = duty_q;
    out_d.status       = res_status_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      job_q        <= JOB_SPEED;
      speed_q      <= '0;
      tick_cnt_q   <= '0;
      pend_q       <= 1'b0;
      powered_q    <= 1'b0;
      target_q     <= '0;
      duty_q       <= '0;
      res_send_q   <= 1'b0;
      res_status_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      job_q        <= job_d;
      speed_q      <= speed_d;
      tick_cnt_q   <= tick_cnt_d;
      pend_q       <= pend_d;
      powered_q    <= powered_d;
      target_q     <= target_d;
      duty_q       <= duty_d;
      res_send_q   <= res_send_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    step_q    <= step_d;
    res_thr_q <= res_thr_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= DUTY_MAX)
    else $error("duty above full scale");

  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_cnt_q <= ADJUST_PERIOD)
    else $error("tick counter past its period");

  a_quiet_throttle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.send |-> out_data_o.throttle == '0)
    else $error("throttle word set on a word without a write");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input taken while a word is still in work");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_OUT)
    else $error("output word loaded outside the output state");

endmodule

`default_nettype wire
